// ----- rtl/core/sup_pkg.sv -----
// ----------------------------------------------------------------------------
// sup_pkg
// Shared types and constants for the stereo 2:3 upsampler: interpolation
// weight, frame queue depth, lane control and frame structures.
// ----------------------------------------------------------------------------
package sup_pkg;

  localparam int unsigned SampleW = 16;

  // one third of 1.0 in q16, the smaller of the two blend weights
  localparam logic signed [SampleW-1:0] WOneThird = 16'sd21846;

  // frames the result queue can hold, at least two
  localparam int unsigned FifoDepth = 4;

  typedef enum logic {
    ModePass = 1'b0,
    ModeUp   = 1'b1
  } mode_e;

  typedef enum logic {
    PhaseFirst  = 1'b0,
    PhaseSecond = 1'b1
  } phase_e;

  typedef struct packed {
    logic   take;
    mode_e  mode;
    phase_e phase;
  } lane_ctrl_t;

  typedef struct packed {
    logic               last;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } frame_t;

  typedef struct packed {
    logic push;
    logic two;
  } push_t;

endpackage

// ----- rtl/core/sup_lane.sv -----
// ----------------------------------------------------------------------------
// sup_lane
// One audio channel: keeps the previous and held samples and forms the
// passthrough, kept or interpolated samples for the current transaction.
// ----------------------------------------------------------------------------
module sup_lane
  import sup_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lane_ctrl_t               ctrl_i,
  input  logic signed [SampleW-1:0] sample_i,
  output logic signed [SampleW-1:0] first_o,
  output logic signed [SampleW-1:0] second_o
);

  logic signed [SampleW-1:0] prev_q, prev_d;
  logic signed [SampleW-1:0] held_q, held_d;
  logic signed [SampleW-1:0] base, other;
  logic signed [SampleW:0]   diff;
  logic signed [32:0]        prod;
  logic signed [SampleW:0]   blend;

  // a*wa + b*wb with wa + wb = 1.0 is base*1.0 + (other - base) * one third
  always_comb begin
    if (ctrl_i.phase == PhaseFirst) begin
      base  = sample_i;
      other = prev_q;
    end else begin
      base  = held_q;
      other = sample_i;
    end
    diff  = {other[SampleW-1], other} - {base[SampleW-1], base};
    prod  = 33'(diff) * 33'(WOneThird);
    blend = {base[SampleW-1], base} + prod[32:16];
  end

  always_comb begin
    first_o  = sample_i;
    second_o = blend[SampleW-1:0];
    if (ctrl_i.mode == ModeUp) begin
      if (ctrl_i.phase == PhaseFirst) begin
        first_o = prev_q;
      end else begin
        first_o = blend[SampleW-1:0];
      end
    end
  end

  always_comb begin
    prev_d = prev_q;
    held_d = held_q;
    if (ctrl_i.take && (ctrl_i.mode == ModeUp)) begin
      if (ctrl_i.phase == PhaseFirst) begin
        held_d = sample_i;
      end else begin
        prev_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      held_q <= '0;
    end else begin
      prev_q <= prev_d;
      held_q <= held_d;
    end
  end

endmodule

// ----- rtl/core/sup_frame_fifo.sv -----
// ----------------------------------------------------------------------------
// sup_frame_fifo
// Queues the stereo frames built from the lane results; takes one or two
// frames per transaction and hands out one frame per ready output cycle.
// ----------------------------------------------------------------------------
module sup_frame_fifo
  import sup_pkg::*;
#(
  parameter int unsigned Depth = FifoDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  wr_i,
  input  frame_t frame_a_i,
  input  frame_t frame_b_i,
  output logic   space_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output frame_t frame_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, wr_next;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign space_o     = (count_q <= CntW'(Depth - 2));
  assign out_valid_o = (count_q != '0);
  assign frame_o     = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_next     = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_i.push) begin
      if (wr_i.two) begin
        wr_ptr_d = ptr_inc(wr_next);
        count_d  = count_d + CntW'(2);
      end else begin
        wr_ptr_d = wr_next;
        count_d  = count_d + CntW'(1);
      end
    end
    if (pop) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
      count_d  = count_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wr_ptr_q] <= frame_a_i;
      if (wr_i.two) begin
        mem_q[wr_next] <= frame_b_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- rtl/core/stereo_two_to_three_upsampler_top.sv -----
// ----------------------------------------------------------------------------
// stereo_two_to_three_upsampler_top
// Stereo sample stream, passed through or upsampled 2:3 by linear
// interpolation; left and right run in two lanes, a frame queue merges them.
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_ready_o    left_sample_i, right_sample_i
//   out      out  out_valid_o / out_ready_i  left_out_o, right_out_o, run_last_o
//   cfg      in   cfg_valid_i / cfg_ready_o  cfg_rate_mode_i
//
// an accepted transaction's frames join the queue behind any frames already held
// passthrough: one item per cycle while the queue has space; 2:3 mode: 3 frames
// per 2 items, paced by the output side handing out one frame per ready cycle
// the frame queue holds Depth frames; input ready drops when under two are free
// reset clears mode, pairing phase, kept samples and the queue
// ----------------------------------------------------------------------------
module stereo_two_to_three_upsampler_top
  import sup_pkg::*;
#(
  parameter int unsigned Depth = FifoDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] left_sample_i,
  input  logic signed [SampleW-1:0] right_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] left_out_o,
  output logic signed [SampleW-1:0] right_out_o,
  output logic                      run_last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_rate_mode_i
);

  mode_e      mode_q, mode_d;
  phase_e     phase_q, phase_d;
  lane_ctrl_t ctrl;
  push_t      wr;
  frame_t     frame_a, frame_b, frame_out;
  logic       take, space;
  logic signed [SampleW-1:0] l_first, l_second, r_first, r_second;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = space;
  assign take        = in_valid_i && in_ready_o;
  assign ctrl        = '{take: take, mode: mode_q, phase: phase_q};

  sup_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (left_sample_i),
    .first_o  (l_first),
    .second_o (l_second)
  );

  sup_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (right_sample_i),
    .first_o  (r_first),
    .second_o (r_second)
  );

  // first item of a pair in 2:3 mode yields the kept frame and one blend
  always_comb begin
    wr.push      = take;
    wr.two       = (mode_q == ModeUp) && (phase_q == PhaseFirst);
    frame_a.left  = l_first;
    frame_a.right = r_first;
    frame_a.last  = !wr.two;
    frame_b.left  = l_second;
    frame_b.right = r_second;
    frame_b.last  = 1'b1;
  end

  sup_frame_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .frame_a_i   (frame_a),
    .frame_b_i   (frame_b),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_o     (frame_out)
  );

  assign left_out_o  = frame_out.left;
  assign right_out_o = frame_out.right;
  assign run_last_o  = frame_out.last;

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    if (cfg_valid_i && cfg_ready_o) begin
      mode_d = mode_e'(cfg_rate_mode_i);
    end
    if (take && (mode_q == ModeUp)) begin
      phase_d = (phase_q == PhaseFirst) ? PhaseSecond : PhaseFirst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModePass;
      phase_q <= PhaseFirst;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ----- rtl/core/sup_checker.sv -----
// ----------------------------------------------------------------------------
// sup_checker
// Port-level checks for the stereo upsampler, bound to the top level.
// ----------------------------------------------------------------------------
module sup_checker
  import sup_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic signed [SampleW-1:0] left_sample_i,
  input logic signed [SampleW-1:0] right_sample_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [SampleW-1:0] left_out_o,
  input logic signed [SampleW-1:0] right_out_o,
  input logic                      run_last_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic                      cfg_rate_mode_i
);

  // a stalled frame stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped under stall");

  // a stalled frame keeps its payload
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(left_out_o) && $stable(right_out_o) && $stable(run_last_o))
    else $error("output payload changed under stall");

  // every transaction leaves at least one frame queued the next cycle
  a_in_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted transaction produced no frame");

  // input only backs up while frames are waiting
  a_ready_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty frame queue");

endmodule

bind stereo_two_to_three_upsampler_top sup_checker u_sup_checker (.*);
